/* design/cbm_pkg.sv */
// Shared constants, types and decode helpers for the cartridge bank mapper.
package cbm_pkg;

  // Reset value of the 8K PRG register is the second-to-last bank.
  localparam int unsigned PRG_8K_BANKS = 32;
  localparam logic [7:0]  PRG8_RESET   = 8'(PRG_8K_BANKS - 2);

  localparam logic [15:0] ADDR_MASK = 16'hF003;

  // Register decode after masking.
  localparam logic [15:0] SEL_PRG16   = 16'h8000;
  localparam logic [15:0] SEL_PRG8    = 16'hC000;
  localparam logic [15:0] SEL_CHR_D0  = 16'hD000;
  localparam logic [15:0] SEL_CHR_D1  = 16'hD001;
  localparam logic [15:0] SEL_CHR_D2  = 16'hD002;
  localparam logic [15:0] SEL_CHR_D3  = 16'hD003;
  localparam logic [15:0] SEL_CHR_E0  = 16'hE000;
  localparam logic [15:0] SEL_CHR_E1  = 16'hE001;
  localparam logic [15:0] SEL_CHR_E2  = 16'hE002;
  localparam logic [15:0] SEL_CHR_E3  = 16'hE003;
  localparam logic [15:0] SEL_MIRROR  = 16'hB003;
  localparam logic [15:0] SEL_LATCH   = 16'hF000;
  localparam logic [15:0] SEL_IRQ_ACK = 16'hF001;
  localparam logic [15:0] SEL_IRQ_CTL = 16'hF002;

  // Mirroring codes (data & 0x7F).
  localparam logic [6:0] MIR_CODE_MASK = 7'h7F;
  localparam logic [6:0] MIR_CODE_VERT = 7'h20;
  localparam logic [6:0] MIR_CODE_HORZ = 7'h24;
  localparam logic [6:0] MIR_CODE_LOW  = 7'h28;
  localparam logic [6:0] MIR_CODE_HI_A = 7'h08;
  localparam logic [6:0] MIR_CODE_HI_B = 7'h2C;

  localparam logic [1:0] MIR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LOW = 2'd2;
  localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

  localparam logic [8:0] PRESCALE_PERIOD = 9'h072;
  localparam logic [7:0] COUNT_TOP       = 8'hFF;

  localparam int unsigned CHR_SLOTS = 8;

  // Write request into the CHR bank store.
  typedef struct packed {
    logic       en;
    logic [2:0] slot;
    logic [7:0] data;
  } chr_wr_t;

  // Read request from the CHR bank store.
  typedef struct packed {
    logic       en;
    logic [2:0] slot;
  } chr_rd_t;

  // CHR slot written by a masked address; the middle two slots of each group of four are swapped.
  function automatic logic [2:0] chr_slot_of(logic [15:0] sel);
    logic [2:0] slot;
    slot = 3'd0;
    unique case (sel)
      SEL_CHR_D0: slot = 3'd0;
      SEL_CHR_D1: slot = 3'd2;
      SEL_CHR_D2: slot = 3'd1;
      SEL_CHR_D3: slot = 3'd3;
      SEL_CHR_E0: slot = 3'd4;
      SEL_CHR_E1: slot = 3'd6;
      SEL_CHR_E2: slot = 3'd5;
      SEL_CHR_E3: slot = 3'd7;
      default:    slot = 3'd0;
    endcase
    return slot;
  endfunction

endpackage

/* design/cbm_chr_store.sv */
// CHR bank store: synchronous memory with per-entry valid bits and write forwarding.
module cbm_chr_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cbm_pkg::chr_wr_t wr_i,
  input  cbm_pkg::chr_rd_t rd_i,
  output logic [7:0]       bank_o
);

  logic [7:0]                     mem_q [cbm_pkg::CHR_SLOTS];
  logic [cbm_pkg::CHR_SLOTS-1:0]  vld_q;
  logic [7:0]                     rdata_q;
  logic [2:0]                     rslot_q;
  logic                           rvld_q;
  logic                           fwd_q;
  logic [7:0]                     fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.slot] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.slot] <= 1'b1;
    end
  end

  // Read returns the old entry; forward a write to the same slot in the same beat.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q    <= mem_q[rd_i.slot];
      rslot_q    <= rd_i.slot;
      rvld_q     <= vld_q[rd_i.slot];
      fwd_q      <= wr_i.en && (wr_i.slot == rd_i.slot);
      fwd_data_q <= wr_i.data;
    end
  end

  // Unwritten slot i reads as bank i.
  assign bank_o = fwd_q  ? fwd_data_q :
                  rvld_q ? rdata_q    : {5'd0, rslot_q};

endmodule

/* design/cartridge_bank_mapper_with_irq_core.sv */
// Top level of the cartridge bank mapper with cycle-driven IRQ counter.
// Each accepted input beat yields its result beat in the next cycle.
// Throughput: one item per cycle; ready falls only while a result waits unclaimed.
// The CHR bank store is read once per item; its read is registered alongside the other state.
// Reset: asynchronous, active low; clears IRQ state and the 16K PRG and mirroring registers,
// loads the 8K PRG reset bank, and marks every CHR slot unwritten so slot i reports bank i.
module cartridge_bank_mapper_with_irq_core #(
  parameter int unsigned PRG_8K_BANKS = cbm_pkg::PRG_8K_BANKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  wdata_i,
  input  logic [6:0]  cycles_i,
  input  logic [2:0]  chr_slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        irq_level_o,
  output logic [7:0]  prg_bank_16k_o,
  output logic [7:0]  prg_bank_8k_o,
  output logic [1:0]  mirror_mode_o,
  output logic [7:0]  chr_bank_o
);

  // Second-to-last 8K bank, low eight bits.
  localparam logic [7:0] PRG8_RESET = 8'(PRG_8K_BANKS - 2);

  logic        accept;
  logic [15:0] sel;
  logic        is_write;
  logic        is_chr;
  logic [6:0]  mir_code;
  logic [8:0]  acc_sum;
  logic [8:0]  acc_left;
  logic        overflow;

  logic        out_valid_q;
  logic [1:0]  irq_ctrl_q,   irq_ctrl_d;
  logic [7:0]  irq_count_q,  irq_count_d;
  logic [7:0]  irq_reload_q, irq_reload_d;
  logic [7:0]  prescale_q,   prescale_d;
  logic        irq_pend_q,   irq_pend_d;
  logic [7:0]  prg16_q,      prg16_d;
  logic [7:0]  prg8_q,       prg8_d;
  logic [1:0]  mirror_q,     mirror_d;

  cbm_pkg::chr_wr_t chr_wr;
  cbm_pkg::chr_rd_t chr_rd;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sel        = address_i & cbm_pkg::ADDR_MASK;
  assign is_write   = !action_i;
  assign mir_code   = wdata_i[6:0] & cbm_pkg::MIR_CODE_MASK;

  always_comb begin
    unique case (sel)
      cbm_pkg::SEL_CHR_D0, cbm_pkg::SEL_CHR_D1, cbm_pkg::SEL_CHR_D2,
      cbm_pkg::SEL_CHR_D3, cbm_pkg::SEL_CHR_E0, cbm_pkg::SEL_CHR_E1,
      cbm_pkg::SEL_CHR_E2, cbm_pkg::SEL_CHR_E3: is_chr = 1'b1;
      default:                                  is_chr = 1'b0;
    endcase
  end

  // Prescaler: at most one counter step per tick, remainder saturated.
  assign acc_sum  = {1'b0, prescale_q} + {2'b00, cycles_i};
  assign overflow = acc_sum >= cbm_pkg::PRESCALE_PERIOD;
  assign acc_left = overflow ? acc_sum - cbm_pkg::PRESCALE_PERIOD : acc_sum;

  always_comb begin
    irq_ctrl_d   = irq_ctrl_q;
    irq_count_d  = irq_count_q;
    irq_reload_d = irq_reload_q;
    prescale_d   = prescale_q;
    irq_pend_d   = irq_pend_q;
    prg16_d      = prg16_q;
    prg8_d       = prg8_q;
    mirror_d     = mirror_q;
    if (is_write) begin
      unique case (sel)
        cbm_pkg::SEL_PRG16: prg16_d = wdata_i;
        cbm_pkg::SEL_PRG8:  prg8_d  = wdata_i;
        cbm_pkg::SEL_MIRROR: begin
          if (mir_code == cbm_pkg::MIR_CODE_HI_A || mir_code == cbm_pkg::MIR_CODE_HI_B) begin
            mirror_d = cbm_pkg::MIR_SINGLE_HI;
          end else if (mir_code == cbm_pkg::MIR_CODE_VERT) begin
            mirror_d = cbm_pkg::MIR_VERTICAL;
          end else if (mir_code == cbm_pkg::MIR_CODE_HORZ) begin
            mirror_d = cbm_pkg::MIR_HORIZONTAL;
          end else if (mir_code == cbm_pkg::MIR_CODE_LOW) begin
            mirror_d = cbm_pkg::MIR_SINGLE_LOW;
          end
        end
        cbm_pkg::SEL_LATCH: irq_reload_d = wdata_i;
        cbm_pkg::SEL_IRQ_ACK: begin
          irq_ctrl_d = {irq_ctrl_q[0], irq_ctrl_q[0]};
          irq_pend_d = 1'b0;
        end
        cbm_pkg::SEL_IRQ_CTL: begin
          irq_ctrl_d = wdata_i[1:0];
          if (wdata_i[1]) begin
            irq_count_d = irq_reload_q;
            prescale_d  = 8'd0;
          end
          irq_pend_d = 1'b0;
        end
        default: ;
      endcase
    end else if (irq_ctrl_q[1]) begin
      if (overflow) begin
        if (irq_count_q == cbm_pkg::COUNT_TOP) begin
          irq_count_d = irq_reload_q;
          irq_pend_d  = 1'b1;
        end else begin
          irq_count_d = irq_count_q + 8'd1;
        end
      end
      prescale_d = acc_left[8] ? 8'hFF : acc_left[7:0];
    end
  end

  // State advances only on an accepted beat, so it doubles as the result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      irq_ctrl_q   <= '0;
      irq_count_q  <= '0;
      irq_reload_q <= '0;
      prescale_q   <= '0;
      irq_pend_q   <= 1'b0;
      prg16_q      <= '0;
      prg8_q       <= PRG8_RESET;
      mirror_q     <= cbm_pkg::MIR_VERTICAL;
    end else begin
      if (accept) begin
        out_valid_q  <= 1'b1;
        irq_ctrl_q   <= irq_ctrl_d;
        irq_count_q  <= irq_count_d;
        irq_reload_q <= irq_reload_d;
        prescale_q   <= prescale_d;
        irq_pend_q   <= irq_pend_d;
        prg16_q      <= prg16_d;
        prg8_q       <= prg8_d;
        mirror_q     <= mirror_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign chr_wr.en   = accept && is_write && is_chr;
  assign chr_wr.slot = cbm_pkg::chr_slot_of(sel);
  assign chr_wr.data = wdata_i;
  assign chr_rd.en   = accept;
  assign chr_rd.slot = chr_slot_i;

  cbm_chr_store u_chr_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (chr_wr),
    .rd_i   (chr_rd),
    .bank_o (chr_bank_o)
  );

  assign out_valid_o    = out_valid_q;
  assign irq_level_o    = irq_pend_q;
  assign prg_bank_16k_o = prg16_q;
  assign prg_bank_8k_o  = prg8_q;
  assign mirror_mode_o  = mirror_q;

  // IRQ only rises from an accepted tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(irq_pend_q) |-> $past(accept && action_i))
    else $error("IRQ raised without an accepted tick");

  // Acknowledge and control writes clear the IRQ.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_write && (sel == cbm_pkg::SEL_IRQ_ACK || sel == cbm_pkg::SEL_IRQ_CTL))
    |=> !irq_pend_q)
    else $error("IRQ not cleared by acknowledge or control write");

  // A tick with the counter disabled leaves prescaler and counter alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && action_i && !irq_ctrl_q[1]) |=> ($stable(prescale_q) && $stable(irq_count_q)))
    else $error("Disabled counter advanced on tick");

endmodule
